// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, ignored while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/slfu_pkg.sv =====
package slfu_pkg;

    localparam int          SLFU_Q_DEPTH       = 2;
    localparam logic [3:0]  SLFU_LAST_IDX      = 4'd14;
    localparam logic [3:0]  SLFU_BLANK         = 4'd10;
    localparam logic [3:0]  SLFU_MCH_MAX       = 4'd9;
    localparam logic [6:0]  SLFU_LINE_MAX      = 7'd99;
    localparam logic [13:0] SLFU_SPEED_MAX     = 14'd9999;
    localparam logic [5:0]  SLFU_ICON_ADDR     = 6'd1;
    localparam logic [5:0]  SLFU_UNITS_LO_ADDR = 6'd5;
    localparam logic [1:0]  SLFU_DIR_NO_TENS   = 2'd1;
    localparam logic [1:0]  SLFU_DIR_NO_UNITS  = 2'd0;

    // Decimal place handled by one conversion step.
    typedef enum logic [1:0] {
        PL_THOU,
        PL_HUND,
        PL_TENS
    } t_place;

    // One formatted snapshot: digit codes plus point controls.
    typedef struct packed {
        logic [3:0] icon;
        logic [3:0] line_t;
        logic [3:0] line_u;
        logic [3:0] mch;
        logic [3:0] thou;
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] units;
        logic       pow;
        logic [1:0] dir;
    } t_snap;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [13:0] place_weight(t_place p);
        logic [13:0] w;
        unique case (p)
            PL_THOU: w = 14'd1000;
            PL_HUND: w = 14'd100;
            PL_TENS: w = 14'd10;
            default: w = 14'd10;
        endcase
        return w;
    endfunction

    // Digit at place p of v, with v below ten times the weight.
    function automatic logic [3:0] dec_digit(logic [13:0] v, t_place p);
        logic [13:0] w;
        logic [3:0]  d;
        w = place_weight(p);
        d = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (v >= 14'(k) * w) begin
                d = 4'(k);
            end
        end
        return d;
    endfunction

    function automatic logic [3:0] icon_nibble(logic [2:0] area);
        logic [3:0] nib;
        case (area)
            3'd1:    nib = 4'h8;
            3'd2:    nib = 4'h4;
            3'd3:    nib = 4'h2;
            3'd4:    nib = 4'h1;
            default: nib = 4'h0;
        endcase
        return nib;
    endfunction

    function automatic logic [7:0] seg_code(logic [3:0] code);
        logic [7:0] seg;
        case (code)
            4'd0:    seg = 8'haf;
            4'd1:    seg = 8'ha0;
            4'd2:    seg = 8'h6d;
            4'd3:    seg = 8'he9;
            4'd4:    seg = 8'he2;
            4'd5:    seg = 8'hcb;
            4'd6:    seg = 8'hcf;
            4'd7:    seg = 8'ha1;
            4'd8:    seg = 8'hef;
            4'd9:    seg = 8'heb;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

// ===== rtl/core/slfu_in_if.sv =====
interface slfu_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  area_sel;
    logic [6:0]  line_no;
    logic [3:0]  mch_no;
    logic [13:0] speed_val;
    logic [1:0]  dir_mode;
    logic        power_on;

    modport source (
        output valid, area_sel, line_no, mch_no, speed_val, dir_mode, power_on,
        input  ready
    );
    modport sink (
        input  valid, area_sel, line_no, mch_no, speed_val, dir_mode, power_on,
        output ready
    );
endinterface

// ===== rtl/core/slfu_out_if.sv =====
interface slfu_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] lcd_addr;
    logic [3:0] lcd_nibble;
    logic       last;

    modport source (
        output valid, lcd_addr, lcd_nibble, last,
        input  ready
    );
    modport sink (
        input  valid, lcd_addr, lcd_nibble, last,
        output ready
    );
endinterface

// ===== rtl/core/segment_lcd_screen_formatter_unit.sv =====
// Segment LCD screen formatter.
// i_snap (sink): one screen snapshot per transaction - area icon, line
//   number, machine digit, speed value, direction code and power flag.
// o_wr (source): fifteen display writes per snapshot, each a 6-bit address
//   and a segment nibble; last marks the fifteenth write.
// Write order: area icon, line tens and units, machine digit, then the
//   speed thousands, hundreds, tens and units, high nibble first per digit.
// Throughput: one write per cycle while the receiver keeps o_wr.ready high,
//   set by the single output register of the write generator. The
//   converter front takes a new snapshot only once the last is pushed
//   into a small queue (QDepth entries), so snapshots are taken while
//   writes still drain.
// Reset (synchronous, active low) empties the queue and drops any snapshot
//   in flight; the output goes invalid on the next edge.
// Receiver stall: the pending write holds steady on o_wr; the generator
//   pauses, the queue fills, then i_snap.ready drops until room frees up.
`include "assert_macros.svh"

module segment_lcd_screen_formatter_unit #(
    parameter int QDepth = slfu_pkg::SLFU_Q_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    slfu_in_if.sink    i_snap,
    slfu_out_if.source o_wr
);
    import slfu_pkg::*;

    t_snap   front_data;
    t_snap   q_head;
    t_q_stat q_stat;
    logic    q_push;
    logic    q_pop;

    // Front: saturation, icon lookup and digit extraction, one place a cycle.
    slfu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_snap   (i_snap),
        .i_q_stat (q_stat),
        .o_push   (q_push),
        .o_data   (front_data)
    );

    // Snapshot queue decoupling conversion from write generation.
    slfu_fifo #(
        .Depth (QDepth)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_data),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    // Back: segment mapping and the fifteen-write sequence.
    slfu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (q_head),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_wr     (o_wr)
    );

    // The closing write of a snapshot is always the speed units low nibble.
    `ASSERT_CLK(a_last_addr, o_wr.valid && o_wr.last |-> o_wr.lcd_addr == SLFU_UNITS_LO_ADDR, "last write at wrong address")
    // The area icon lights at most one segment.
    `ASSERT_CLK(a_icon_onehot, o_wr.valid && o_wr.lcd_addr == SLFU_ICON_ADDR |-> $onehot0(o_wr.lcd_nibble), "icon nibble not one-hot")
    // The front never pushes into a full queue.
    `ASSERT_CLK(a_no_overflow, q_push |-> !q_stat.full, "push into full queue")
    // No write is offered on the edge after a reset edge.
    `ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_wr.valid, "output valid after reset")

endmodule

// ===== rtl/core/slfu_front.sv =====
module slfu_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    slfu_in_if.sink         i_snap,
    input  slfu_pkg::t_q_stat i_q_stat,
    output logic            o_push,
    output slfu_pkg::t_snap o_data
);
    import slfu_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_PUSH
    } t_state;

    t_state      r_state;
    t_place      r_place;
    logic [13:0] r_rest;
    t_snap       r_snap;

    logic        accept;
    logic [6:0]  line_sat;
    logic [3:0]  line_t;
    logic [6:0]  line_rem;
    logic [3:0]  dig;
    logic [13:0] rest_next;

    assign i_snap.ready = (r_state == ST_IDLE);
    assign accept       = i_snap.valid && i_snap.ready;
    assign o_push       = (r_state == ST_PUSH) && !i_q_stat.full;
    assign o_data       = r_snap;

    assign line_sat = (i_snap.line_no > SLFU_LINE_MAX) ? SLFU_LINE_MAX : i_snap.line_no;
    assign line_t   = dec_digit(14'(line_sat), PL_TENS);
    assign line_rem = line_sat - 7'(place_weight(PL_TENS) * 14'(line_t));

    // One decimal digit of the speed per cycle.
    assign dig       = dec_digit(r_rest, r_place);
    assign rest_next = r_rest - place_weight(r_place) * 14'(dig);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state       <= ST_CONV;
                        r_place       <= PL_THOU;
                        r_rest        <= (i_snap.speed_val > SLFU_SPEED_MAX) ?
                                         SLFU_SPEED_MAX : i_snap.speed_val;
                        r_snap.icon   <= icon_nibble(i_snap.area_sel);
                        r_snap.line_t <= line_t;
                        r_snap.line_u <= line_rem[3:0];
                        r_snap.mch    <= (i_snap.mch_no > SLFU_MCH_MAX) ?
                                         SLFU_BLANK : i_snap.mch_no;
                        r_snap.pow    <= i_snap.power_on;
                        r_snap.dir    <= i_snap.dir_mode;
                    end
                end
                ST_CONV: begin
                    r_rest <= rest_next;
                    unique case (r_place)
                        PL_THOU: begin
                            r_snap.thou <= (dig == 4'd0) ? SLFU_BLANK : dig;
                            r_place     <= PL_HUND;
                        end
                        PL_HUND: begin
                            r_snap.hund <= dig;
                            r_place     <= PL_TENS;
                        end
                        PL_TENS: begin
                            r_snap.tens  <= dig;
                            r_snap.units <= rest_next[3:0];
                            r_state      <= ST_PUSH;
                        end
                        default: r_place <= PL_THOU;
                    endcase
                end
                ST_PUSH: begin
                    if (!i_q_stat.full) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/slfu_fifo.sv =====
module slfu_fifo #(
    parameter int Depth = slfu_pkg::SLFU_Q_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  slfu_pkg::t_snap   i_data,
    input  logic              i_pop,
    output slfu_pkg::t_snap   o_head,
    output slfu_pkg::t_q_stat o_stat
);
    import slfu_pkg::*;

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);

    t_snap         r_mem [Depth];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
        return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
    endfunction

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CW'(Depth));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/core/slfu_back.sv =====
module slfu_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  slfu_pkg::t_snap   i_head,
    input  slfu_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    slfu_out_if.source        o_wr
);
    import slfu_pkg::*;

    logic       r_have;
    logic [3:0] r_idx;
    t_snap      r_item;
    logic       r_out_valid;
    logic [5:0] r_addr;
    logic [3:0] r_nib;
    logic       r_last;

    logic       load_ok;
    logic       done_item;
    logic [3:0] pos;
    logic [3:0] code;
    logic       point;
    logic [5:0] base;
    logic [7:0] seg;
    logic [5:0] w_addr;
    logic [3:0] w_nib;

    assign load_ok   = !r_out_valid || o_wr.ready;
    assign done_item = r_have && load_ok && (r_idx == SLFU_LAST_IDX);
    assign o_pop     = !i_q_stat.empty && (!r_have || done_item);

    // Writes 1..14 are digit pairs: pos[3:1] picks the digit, pos[0] the half.
    assign pos = r_idx - 4'd1;

    always_comb begin
        case (pos[3:1])
            3'd0: begin code = r_item.line_t; point = 1'b1; base = 6'd16; end
            3'd1: begin code = r_item.line_u; point = 1'b0; base = 6'd14; end
            3'd2: begin code = r_item.mch;    point = 1'b1; base = 6'd12; end
            3'd3: begin code = r_item.thou;   point = 1'b1; base = 6'd10; end
            3'd4: begin code = r_item.hund;   point = r_item.pow; base = 6'd8; end
            3'd5: begin
                code  = r_item.tens;
                point = (r_item.dir != SLFU_DIR_NO_TENS);
                base  = 6'd6;
            end
            default: begin
                code  = r_item.units;
                point = (r_item.dir != SLFU_DIR_NO_UNITS);
                base  = 6'd4;
            end
        endcase
    end

    assign seg = seg_code(code);

    always_comb begin
        if (r_idx == 4'd0) begin
            w_addr = SLFU_ICON_ADDR;
            w_nib  = r_item.icon;
        end else if (!pos[0]) begin
            w_addr = base;
            w_nib  = {seg[7:5], seg[4] | point};
        end else begin
            w_addr = base + 6'd1;
            w_nib  = seg[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_ok) begin
                r_out_valid <= r_have;
            end
            if (r_have && load_ok) begin
                r_addr <= w_addr;
                r_nib  <= w_nib;
                r_last <= (r_idx == SLFU_LAST_IDX);
                if (r_idx != SLFU_LAST_IDX) begin
                    r_idx <= r_idx + 4'd1;
                end
            end
            if (o_pop) begin
                r_item <= i_head;
                r_idx  <= 4'd0;
                r_have <= 1'b1;
            end else if (done_item) begin
                r_have <= 1'b0;
            end
        end
    end

    assign o_wr.valid      = r_out_valid;
    assign o_wr.lcd_addr   = r_addr;
    assign o_wr.lcd_nibble = r_nib;
    assign o_wr.last       = r_last;

endmodule
